>>> hdl/shs_pkg.sv
// ----------------------------------------------------------------------------
// shs_pkg
// Types, codes and reset values shared by the stall homing sequencer files.
// ----------------------------------------------------------------------------
package shs_pkg;

  localparam int POSITION_BITS_DEF = 32;
  localparam int COUNT_BITS_DEF    = 8;

  // result queue depth, must be a power of two and at least two
  localparam int RESULT_DEPTH = 4;

  // configuration register indexes
  localparam logic [2:0] CFG_SEARCH_TORQUE      = 3'd0;
  localparam logic [2:0] CFG_STALL_SPEED        = 3'd1;
  localparam logic [2:0] CFG_STALL_COUNT_LIMIT  = 3'd2;
  localparam logic [2:0] CFG_SEARCH_ANGLE_LIMIT = 3'd3;
  localparam logic [2:0] CFG_CENTER_THRESHOLD   = 3'd4;
  localparam logic [2:0] CFG_APPROACH_SPEED     = 3'd5;
  localparam logic [2:0] CFG_CLEARANCE          = 3'd6;

  // configuration reset values
  localparam logic [10:0] SEARCH_TORQUE_RST      = 11'd100;
  localparam logic [14:0] STALL_SPEED_RST        = 15'd2;
  localparam logic [7:0]  STALL_COUNT_LIMIT_RST  = 8'd50;
  localparam logic [30:0] SEARCH_ANGLE_LIMIT_RST = 31'd108000;
  localparam logic [30:0] CENTER_THRESHOLD_RST   = 31'd500;
  localparam logic [30:0] APPROACH_SPEED_RST     = 31'd10000;
  localparam logic [29:0] CLEARANCE_RST          = 30'd1000;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_POS      = 3'd1,
    PH_NEG      = 3'd2,
    PH_APPROACH = 3'd3,
    PH_DONE     = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    CMD_OFF      = 3'd0,
    CMD_TORQUE   = 3'd1,
    CMD_STOP     = 3'd2,
    CMD_SPEED    = 3'd3,
    CMD_POSITION = 3'd4
  } cmd_kind_t;

  typedef struct packed {
    logic [10:0] search_torque;
    logic [14:0] stall_speed;
    logic [7:0]  stall_count_limit;
    logic [30:0] search_angle_limit;
    logic [30:0] center_threshold;
    logic [30:0] approach_speed;
    logic [29:0] clearance;
  } cfg_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic signed [31:0] value;
    logic               last;
    logic               done;
    logic signed [31:0] low;
    logic signed [31:0] high;
    logic signed [31:0] center;
  } result_t;

  function automatic result_t mk_result(input cmd_kind_t kind, input logic signed [31:0] value,
                                        input logic last);
    result_t r;
    r        = '0;
    r.kind   = kind;
    r.value  = value;
    r.last   = last;
    return r;
  endfunction

endpackage

>>> hdl/shs_step.sv
// ----------------------------------------------------------------------------
// shs_step
// Combinational step: next homing state and up to two results for one item.
// ----------------------------------------------------------------------------
module shs_step #(
  parameter int POS_W   = shs_pkg::POSITION_BITS_DEF,
  parameter int COUNT_W = shs_pkg::COUNT_BITS_DEF
) (
  input  logic                      mode,
  input  logic signed [15:0]        speed,
  input  logic signed [POS_W-1:0]   pos,
  input  shs_pkg::cfg_t             cfg,
  input  shs_pkg::phase_t           phase,
  input  logic [COUNT_W-1:0]        count,
  input  logic signed [POS_W-1:0]   upper,
  input  logic signed [POS_W-1:0]   lower,
  input  logic signed [POS_W-1:0]   center,
  output shs_pkg::phase_t           phase_next,
  output logic [COUNT_W-1:0]        count_next,
  output logic signed [POS_W-1:0]   upper_next,
  output logic signed [POS_W-1:0]   lower_next,
  output logic signed [POS_W-1:0]   center_next,
  output shs_pkg::result_t          res0,
  output shs_pkg::result_t          res1,
  output logic [1:0]                n_res
);

  localparam int CMW = (COUNT_W > 8) ? COUNT_W : 8;
  localparam logic signed [34:0] MAXV = (35'sd1 <<< (POS_W - 1)) - 35'sd1;
  localparam logic signed [34:0] MINV = -MAXV - 35'sd1;

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [34:0] v);
    logic signed [POS_W-1:0] r;
    if (v > MAXV) r = MAXV[POS_W-1:0];
    else if (v < MINV) r = MINV[POS_W-1:0];
    else r = v[POS_W-1:0];
    return r;
  endfunction

  logic signed [16:0]      spd17, ss17;
  logic                    stalled;
  logic [COUNT_W-1:0]      cnt_bumped;
  logic                    reached;
  logic signed [32:0]      pos33, bnd33;
  logic                    past_hi, past_lo;
  logic signed [POS_W:0]   sum, sum_adj, span, span_adj;
  logic signed [POS_W-1:0] ctr_new, half;
  logic signed [33:0]      diff, thr;
  logic                    below;
  logic signed [34:0]      lo_w, hi_w, clr35;
  logic signed [31:0]      torque32, appr32;

  always_comb begin
    spd17   = 17'(speed);
    ss17    = $signed({2'b00, cfg.stall_speed});
    stalled = (phase == shs_pkg::PH_POS) ? (spd17 < ss17) : (spd17 > -ss17);
    if (!stalled) cnt_bumped = '0;
    else if (&count) cnt_bumped = count;
    else cnt_bumped = count + COUNT_W'(1);
    reached = CMW'(cnt_bumped) >= CMW'(cfg.stall_count_limit);

    pos33   = 33'(pos);
    bnd33   = $signed({2'b00, cfg.search_angle_limit});
    past_hi = pos33 > bnd33;
    past_lo = pos33 < -bnd33;

    // center of upper and the new lower, halved toward zero
    sum     = (POS_W+1)'(upper) + (POS_W+1)'(pos);
    sum_adj = sum + $signed((POS_W+1)'(sum[POS_W]));
    ctr_new = sum_adj[POS_W:1];

    diff  = 34'(pos) - 34'(center);
    thr   = $signed({3'b000, cfg.center_threshold});
    below = diff < -thr;

    span     = (POS_W+1)'(upper) - (POS_W+1)'(lower);
    span_adj = span + $signed((POS_W+1)'(span[POS_W]));
    half     = span_adj[POS_W:1];
    clr35    = $signed({5'b00000, cfg.clearance});
    lo_w     = 35'(center) - 35'(half) + clr35;
    hi_w     = 35'(center) + 35'(half) - clr35;

    torque32 = $signed(32'(cfg.search_torque));
    appr32   = $signed(32'(cfg.approach_speed));

    phase_next  = phase;
    count_next  = count;
    upper_next  = upper;
    lower_next  = lower;
    center_next = center;
    res0        = '0;
    res1        = '0;
    n_res       = 2'd0;

    if (!mode) begin
      phase_next = shs_pkg::PH_POS;
      count_next = '0;
      res0       = shs_pkg::mk_result(shs_pkg::CMD_OFF, 32'sd0, 1'b0);
      res1       = shs_pkg::mk_result(shs_pkg::CMD_TORQUE, torque32, 1'b1);
      n_res      = 2'd2;
    end else begin
      unique case (phase)
        shs_pkg::PH_POS: begin
          count_next = cnt_bumped;
          if (reached || past_hi) begin
            upper_next = pos;
            count_next = '0;
            phase_next = shs_pkg::PH_NEG;
            res0       = shs_pkg::mk_result(shs_pkg::CMD_STOP, 32'sd0, 1'b0);
            res1       = shs_pkg::mk_result(shs_pkg::CMD_TORQUE, -torque32, 1'b1);
            n_res      = 2'd2;
          end else begin
            res0  = shs_pkg::mk_result(shs_pkg::CMD_TORQUE, torque32, 1'b1);
            n_res = 2'd1;
          end
        end
        shs_pkg::PH_NEG: begin
          count_next = cnt_bumped;
          if (reached || past_lo) begin
            lower_next  = pos;
            count_next  = '0;
            center_next = ctr_new;
            phase_next  = shs_pkg::PH_APPROACH;
            res0        = shs_pkg::mk_result(shs_pkg::CMD_STOP, 32'sd0, 1'b0);
            res1        = shs_pkg::mk_result(shs_pkg::CMD_SPEED, appr32, 1'b1);
            n_res       = 2'd2;
          end else begin
            res0  = shs_pkg::mk_result(shs_pkg::CMD_TORQUE, -torque32, 1'b1);
            n_res = 2'd1;
          end
        end
        shs_pkg::PH_APPROACH: begin
          n_res = 2'd1;
          if (below) begin
            res0 = shs_pkg::mk_result(shs_pkg::CMD_SPEED, appr32, 1'b1);
          end else begin
            phase_next  = shs_pkg::PH_DONE;
            res0        = shs_pkg::mk_result(shs_pkg::CMD_POSITION, 32'(center), 1'b1);
            res0.done   = 1'b1;
            res0.low    = 32'(sat_pos(lo_w));
            res0.high   = 32'(sat_pos(hi_w));
            res0.center = 32'(center);
          end
        end
        default: begin
          // reports while idle or done are dropped
        end
      endcase
    end
  end

endmodule

>>> hdl/shs_result_fifo.sv
// ----------------------------------------------------------------------------
// shs_result_fifo
// Small result queue: takes up to two results a cycle, gives one a cycle.
// ----------------------------------------------------------------------------
module shs_result_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic [1:0]       push_n,
  input  shs_pkg::result_t res0,
  input  shs_pkg::result_t res1,
  input  logic             pop,
  output logic             room,
  output logic             not_empty,
  output shs_pkg::result_t head
);

  localparam int DEPTH = shs_pkg::RESULT_DEPTH;
  localparam int PTRW  = $clog2(DEPTH);
  localparam int CNTW  = $clog2(DEPTH + 1);

  shs_pkg::result_t mem [DEPTH];
  logic [PTRW-1:0]  wr, rd;
  logic [CNTW-1:0]  count, count_next;

  assign room      = count <= CNTW'(DEPTH - 2);
  assign not_empty = count != '0;
  assign head      = mem[rd];

  always_comb begin
    count_next = count + CNTW'(push_n) - CNTW'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr    <= '0;
      rd    <= '0;
      count <= '0;
    end else begin
      wr    <= wr + PTRW'(push_n);
      if (pop) rd <= rd + PTRW'(1);
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) mem[wr] <= res0;
    if (push_n == 2'd2) mem[wr + PTRW'(1)] <= res1;
  end

endmodule

>>> hdl/stall_homing_sequencer.sv
// ----------------------------------------------------------------------------
// stall_homing_sequencer
// Finds both end stops of a geared actuator by stall detection, then moves
// to the center and reports the narrowed travel limits.
// ----------------------------------------------------------------------------
//   channel  handshake            payload
//   item     item_valid/stall     mode, measured_speed, measured_position
//   result   result_valid/stall   command_kind .. center_position
//   config   cfg_valid/ready      cfg_index, cfg_data
//
// An item waits in the input register; the step logic pushes its zero,
// one or two results into a 4-entry result queue; one item per cycle
// while item_stall is low. Results leave one per cycle unless result_stall
// is high. item_stall is high while the input register holds an item and
// the queue has no room for two results. Reset clears the phase, counters,
// extremes and queue, and loads the config registers with reset values.
module stall_homing_sequencer #(
  parameter int POSITION_BITS = shs_pkg::POSITION_BITS_DEF,
  parameter int COUNT_BITS    = shs_pkg::COUNT_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic               mode,
  input  logic signed [15:0] measured_speed,
  input  logic signed [31:0] measured_position,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [2:0]         command_kind,
  output logic signed [31:0] command_value,
  output logic               last_of_run,
  output logic               homing_done,
  output logic signed [31:0] low_limit,
  output logic signed [31:0] high_limit,
  output logic signed [31:0] center_position,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int PW = (POSITION_BITS > 32) ? 32 : POSITION_BITS;

  shs_pkg::cfg_t           cfg;
  shs_pkg::phase_t         phase, phase_next;
  logic [COUNT_BITS-1:0]   stall_count, stall_count_next;
  logic signed [PW-1:0]    upper_extreme, upper_extreme_next;
  logic signed [PW-1:0]    lower_extreme, lower_extreme_next;
  logic signed [PW-1:0]    center_reg, center_reg_next;

  logic                    hold_valid;
  logic                    hold_mode;
  logic signed [15:0]      hold_speed;
  logic signed [PW-1:0]    hold_pos;

  shs_pkg::result_t        res0, res1, head;
  logic [1:0]              n_res;
  logic                    room, fire, item_take, pop;

  assign cfg_ready  = 1'b1;
  assign item_stall = hold_valid && !room;
  assign item_take  = item_valid && !item_stall;
  assign fire       = hold_valid && room;
  assign pop        = result_valid && !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.search_torque      <= shs_pkg::SEARCH_TORQUE_RST;
      cfg.stall_speed        <= shs_pkg::STALL_SPEED_RST;
      cfg.stall_count_limit  <= shs_pkg::STALL_COUNT_LIMIT_RST;
      cfg.search_angle_limit <= shs_pkg::SEARCH_ANGLE_LIMIT_RST;
      cfg.center_threshold   <= shs_pkg::CENTER_THRESHOLD_RST;
      cfg.approach_speed     <= shs_pkg::APPROACH_SPEED_RST;
      cfg.clearance          <= shs_pkg::CLEARANCE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        shs_pkg::CFG_SEARCH_TORQUE:      cfg.search_torque      <= cfg_data[10:0];
        shs_pkg::CFG_STALL_SPEED:        cfg.stall_speed        <= cfg_data[14:0];
        shs_pkg::CFG_STALL_COUNT_LIMIT:  cfg.stall_count_limit  <= cfg_data[7:0];
        shs_pkg::CFG_SEARCH_ANGLE_LIMIT: cfg.search_angle_limit <= cfg_data[30:0];
        shs_pkg::CFG_CENTER_THRESHOLD:   cfg.center_threshold   <= cfg_data[30:0];
        shs_pkg::CFG_APPROACH_SPEED:     cfg.approach_speed     <= cfg_data[30:0];
        shs_pkg::CFG_CLEARANCE:          cfg.clearance          <= cfg_data[29:0];
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else begin
      hold_valid <= item_take || (hold_valid && !fire);
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      hold_mode  <= mode;
      hold_speed <= measured_speed;
      hold_pos   <= measured_position[PW-1:0];
    end
  end

  shs_step #(
    .POS_W   (PW),
    .COUNT_W (COUNT_BITS)
  ) u_step (
    .mode        (hold_mode),
    .speed       (hold_speed),
    .pos         (hold_pos),
    .cfg         (cfg),
    .phase       (phase),
    .count       (stall_count),
    .upper       (upper_extreme),
    .lower       (lower_extreme),
    .center      (center_reg),
    .phase_next  (phase_next),
    .count_next  (stall_count_next),
    .upper_next  (upper_extreme_next),
    .lower_next  (lower_extreme_next),
    .center_next (center_reg_next),
    .res0        (res0),
    .res1        (res1),
    .n_res       (n_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= shs_pkg::PH_IDLE;
      stall_count   <= '0;
      upper_extreme <= '0;
      lower_extreme <= '0;
      center_reg    <= '0;
    end else if (fire) begin
      phase         <= phase_next;
      stall_count   <= stall_count_next;
      upper_extreme <= upper_extreme_next;
      lower_extreme <= lower_extreme_next;
      center_reg    <= center_reg_next;
    end
  end

  shs_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_n    (fire ? n_res : 2'd0),
    .res0      (res0),
    .res1      (res1),
    .pop       (pop),
    .room      (room),
    .not_empty (result_valid),
    .head      (head)
  );

  assign command_kind    = head.kind;
  assign command_value   = head.value;
  assign last_of_run     = head.last;
  assign homing_done     = head.done;
  assign low_limit       = head.low;
  assign high_limit      = head.high;
  assign center_position = head.center;

endmodule

>>> hdl/shs_checker.sv
// ----------------------------------------------------------------------------
// shs_checker
// Port-level checks of the stall homing sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module shs_checker (
  input logic               clk,
  input logic               rst,
  input logic               item_valid,
  input logic               item_stall,
  input logic               mode,
  input logic signed [15:0] measured_speed,
  input logic signed [31:0] measured_position,
  input logic               result_valid,
  input logic               result_stall,
  input logic [2:0]         command_kind,
  input logic signed [31:0] command_value,
  input logic               last_of_run,
  input logic               homing_done,
  input logic signed [31:0] low_limit,
  input logic signed [31:0] high_limit,
  input logic signed [31:0] center_position,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic [2:0]         cfg_index,
  input logic [31:0]        cfg_data
);

  // queue is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result pending after reset");

  a_done_is_position: assert property (@(posedge clk) disable iff (rst)
    result_valid && homing_done |->
      command_kind == shs_pkg::CMD_POSITION && last_of_run && command_value == center_position)
    else $error("done result is not the final position command");

  // off and stop always open a pair of results
  a_first_of_pair: assert property (@(posedge clk) disable iff (rst)
    result_valid && (command_kind == shs_pkg::CMD_OFF || command_kind == shs_pkg::CMD_STOP)
      |-> !last_of_run && command_value == 32'sd0)
    else $error("off or stop result marked last");

  a_limits_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !homing_done |->
      low_limit == 32'sd0 && high_limit == 32'sd0 && center_position == 32'sd0)
    else $error("limits shown before homing is done");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(command_value)
      && $stable(command_kind))
    else $error("stalled result changed");

endmodule

bind stall_homing_sequencer shs_checker u_shs_checker (.*);
